@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rgd_pkg.sv @@
`timescale 1ns / 1ps

package rgd_pkg;

   localparam int BYTE_W   = 8;
   localparam int TARGET_W = 2;
   localparam int GAIN_W   = 16;
   localparam int PEAK_W   = 31;
   localparam int ACCUM_W  = 24;
   localparam int COUNT_W  = 6;

   // Frame target codes
   localparam logic [TARGET_W-1:0] TGT_NONE  = 2'd0;
   localparam logic [TARGET_W-1:0] TGT_TRACK = 2'd1;
   localparam logic [TARGET_W-1:0] TGT_ALBUM = 2'd2;

   localparam logic [BYTE_W-1:0] CHAN_MASTER = 8'd1;

   // Number of peak bytes that contribute to the value
   localparam logic [COUNT_W-1:0] PEAK_USED_BYTES = 6'd3;

   typedef enum logic [2:0] {
      PH_CHAN    = 3'd0,
      PH_GAIN_HI = 3'd1,
      PH_GAIN_LO = 3'd2,
      PH_BITS    = 3'd3,
      PH_PEAK    = 3'd4
   } phase_type;

   typedef struct packed {
      logic [TARGET_W-1:0] gain_target;
      logic [GAIN_W-1:0]   gain_q9;
      logic [PEAK_W-1:0]   peak_q23;
   } result_type;

endpackage

@@ sv/rva2_gain_record_decoder_top.sv @@
`timescale 1ns / 1ps
// The byte that ends a record yields its result, registered in the output register (or skid slot if rsp stalls).
// Throughput: one payload byte per cycle while req_tready is high; record registers update in a single pass per byte.
// req_tready drops only while both the output register and the skid slot hold results.
// Reset: synchronous, active high; clears record phase, latched target and the output slots.

module rva2_gain_record_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // Payload byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [2:0]  req_tuser,   // [1:0] frame_target, [2] first_byte
   input  logic        req_tlast,   // last_byte
   // Master-channel gain results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] gain_q9, [46:16] peak_q23, [47] zero
   output logic [1:0]  rsp_tuser    // [1:0] gain_target
);

   logic                 in_fire;
   logic                 res_valid;
   rgd_pkg::result_type  res_data;
   rgd_pkg::result_type  out_data;

   // A byte transfers whenever the skid slot is free; the parser never stalls
   assign in_fire = req_tvalid && req_tready;

   // Record parser: channel, gain, bit count, peak bytes; emits at most one
   // result per byte, for a finished master-channel record of a known target
   rgd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_fire      (in_fire),
      .data_byte    (req_tdata),
      .frame_target (req_tuser[1:0]),
      .first_byte   (req_tuser[2]),
      .last_byte    (req_tlast),
      .res_valid    (res_valid),
      .res_data     (res_data)
   );

   // Output register plus skid slot: hold a result while rsp stalls and keep
   // taking bytes until both slots are full
   rgd_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res_data),
      .can_accept (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   // Pack the result fields, lowest field first, pad to whole bytes
   assign rsp_tdata = {1'b0, out_data.peak_q23, out_data.gain_q9};
   assign rsp_tuser = out_data.gain_target;

endmodule

@@ sv/rgd_parser.sv @@
`timescale 1ns / 1ps

module rgd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_fire,
   input  logic [rgd_pkg::BYTE_W-1:0]    data_byte,
   input  logic [rgd_pkg::TARGET_W-1:0]  frame_target,
   input  logic                          first_byte,
   input  logic                          last_byte,
   output logic                          res_valid,
   output rgd_pkg::result_type           res_data
);

   rgd_pkg::phase_type                 phase_ff, phase_in, phase_eff;
   logic [rgd_pkg::TARGET_W-1:0]       target_ff, target_in, target_eff;
   logic [rgd_pkg::BYTE_W-1:0]         chan_ff, chan_in;
   logic [rgd_pkg::GAIN_W-1:0]         gain_ff, gain_in;
   logic [rgd_pkg::BYTE_W-1:0]         bits_ff, bits_in;
   logic [rgd_pkg::ACCUM_W-1:0]        accum_ff, accum_in;
   logic [rgd_pkg::COUNT_W-1:0]        left_ff, left_in;
   logic [rgd_pkg::COUNT_W-1:0]        index_ff, index_in;
   logic [rgd_pkg::BYTE_W:0]           bits_round;
   logic [2:0]                         shift;
   logic                               finish;
   logic                               target_ok;

   always_comb begin
      phase_eff  = first_byte ? rgd_pkg::PH_CHAN : phase_ff;
      target_eff = first_byte ? frame_target : target_ff;

      phase_in   = phase_eff;
      target_in  = target_eff;
      chan_in    = chan_ff;
      gain_in    = gain_ff;
      bits_in    = bits_ff;
      accum_in   = accum_ff;
      left_in    = left_ff;
      index_in   = index_ff;
      finish     = 1'b0;
      bits_round = {1'b0, data_byte} + 9'd7;

      case (phase_eff)
         rgd_pkg::PH_CHAN: begin
            chan_in  = data_byte;
            phase_in = rgd_pkg::PH_GAIN_HI;
         end
         rgd_pkg::PH_GAIN_HI: begin
            gain_in  = {data_byte, 8'h00};
            phase_in = rgd_pkg::PH_GAIN_LO;
         end
         rgd_pkg::PH_GAIN_LO: begin
            gain_in  = {gain_ff[15:8], data_byte};
            phase_in = rgd_pkg::PH_BITS;
         end
         rgd_pkg::PH_BITS: begin
            bits_in  = data_byte;
            accum_in = '0;
            index_in = '0;
            left_in  = bits_round[8:3];
            if (bits_round[8:3] == '0) begin
               finish   = 1'b1;
               phase_in = rgd_pkg::PH_CHAN;
            end else begin
               phase_in = rgd_pkg::PH_PEAK;
            end
         end
         default: begin
            // Peak bytes: only the first three land in the accumulator
            if (index_ff < rgd_pkg::PEAK_USED_BYTES) begin
               case (index_ff[1:0])
                  2'd0:    accum_in = accum_ff | {data_byte, 16'h0000};
                  2'd1:    accum_in = accum_ff | {8'h00, data_byte, 8'h00};
                  default: accum_in = accum_ff | {16'h0000, data_byte};
               endcase
            end
            index_in = index_ff + 6'd1;
            if (left_ff != '0) begin
               left_in = left_ff - 6'd1;
            end
            if (left_in == '0) begin
               finish   = 1'b1;
               phase_in = rgd_pkg::PH_CHAN;
            end
         end
      endcase

      if (last_byte) begin
         phase_in  = rgd_pkg::PH_CHAN;
         target_in = rgd_pkg::TGT_NONE;
      end

      target_ok = (target_eff inside {rgd_pkg::TGT_TRACK, rgd_pkg::TGT_ALBUM});
      res_valid = in_fire && finish && target_ok && (chan_ff == rgd_pkg::CHAN_MASTER);

      // Scale by 2^-((bits-1) mod 8); zero bits yields zero peak
      shift                = bits_in[2:0] - 3'd1;
      res_data.gain_target = target_eff;
      res_data.gain_q9     = gain_ff;
      if (bits_in == '0) begin
         res_data.peak_q23 = '0;
      end else begin
         res_data.peak_q23 = {accum_in, 7'b0000000} >> shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rgd_pkg::PH_CHAN;
         target_ff <= rgd_pkg::TGT_NONE;
      end else if (in_fire) begin
         phase_ff  <= phase_in;
         target_ff <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         chan_ff  <= chan_in;
         gain_ff  <= gain_in;
         bits_ff  <= bits_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         index_ff <= index_in;
      end
   end

endmodule

@@ sv/rgd_out_buffer.sv @@
`timescale 1ns / 1ps

module rgd_out_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rgd_pkg::result_type  push_data,
   output logic                 can_accept,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rgd_pkg::result_type  out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   rgd_pkg::result_type  main_ff, main_in;
   rgd_pkg::result_type  skid_ff, skid_in;

   // Push only arrives while the skid slot is empty
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         main_valid_in = skid_valid_ff || push;
         main_in       = skid_valid_ff ? skid_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign can_accept = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

endmodule

@@ sv/rgd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `ASSERT_IMPLIES(a_rsp_target, clock, reset, rsp_tvalid, rsp_tuser == 2'd1 || rsp_tuser == 2'd2, "result without track or album target")
   `ASSERT_IMPLIES(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[47] == 1'b0, "result pad bit set")
   `ASSERT_IMPLIES(a_rsp_cause, clock, reset, rsp_tvalid && !$past(rsp_tvalid), $past(req_tvalid && req_tready), "result without a preceding byte transfer")
   `ASSERT_IMPLIES(a_reset_empty, clock, 1'b0, $fell(reset), !rsp_tvalid, "result present after reset")

endmodule

bind rva2_gain_record_decoder_top rgd_checker u_rgd_checker (.*);

@@ bench/rva2_gain_record_decoder_top_test.sv @@
`timescale 1ns / 1ps

module rva2_gain_record_decoder_top_test;
   import rgd_pkg::*;

   localparam int CLOCK_HALF_NS    = 6;
   localparam int RESET_CYCLES     = 6;
   localparam int ITEMS_PER_PHASE  = 430;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES    = 4;
   localparam int REPORT_LIMIT     = 10;
   localparam longint TIMEOUT_NS   = 3_000_000;

   // Target code 3 has no name in the package; it must behave like "none".
   localparam logic [TARGET_W-1:0] TGT_RESERVED = 2'd3;

   // Tracks the record parser state byte by byte and keeps the gain results
   // that the block owes us, oldest first.
   class gain_tracker;
      phase_type           phase;
      logic [BYTE_W-1:0]   chan;
      logic [GAIN_W-1:0]   gain;
      logic [BYTE_W-1:0]   bit_count;
      logic [ACCUM_W-1:0]  accum;
      logic [COUNT_W-1:0]  bytes_left;
      logic [COUNT_W-1:0]  byte_idx;
      logic [TARGET_W-1:0] target;
      result_type          pending_gains[$];
      int                  bytes_taken;
      int                  gains_checked;
      int                  errors;

      function new();
         phase         = PH_CHAN;
         chan          = '0;
         gain          = '0;
         bit_count     = '0;
         accum         = '0;
         bytes_left    = '0;
         byte_idx      = '0;
         target        = TGT_NONE;
         bytes_taken   = 0;
         gains_checked = 0;
         errors        = 0;
      endfunction

      function void take_byte(input logic [BYTE_W-1:0] b, input logic [TARGET_W-1:0] t,
                              input logic first, input logic last);
         result_type g;
         int         sh;
         bit         done;
         done = 1'b0;
         bytes_taken++;
         // A first byte drops whatever record was in progress.
         if (first) begin
            phase  = PH_CHAN;
            target = t;
         end
         case (phase)
            PH_CHAN: begin
               chan  = b;
               phase = PH_GAIN_HI;
            end
            PH_GAIN_HI: begin
               gain  = {b, 8'h00};
               phase = PH_GAIN_LO;
            end
            PH_GAIN_LO: begin
               gain[7:0] = b;
               phase     = PH_BITS;
            end
            PH_BITS: begin
               bit_count  = b;
               accum      = '0;
               byte_idx   = '0;
               bytes_left = COUNT_W'((int'(b) + 7) >> 3);
               if (bytes_left == 0) begin
                  done = 1'b1;
               end else begin
                  phase = PH_PEAK;
               end
            end
            default: begin
               // Only the first three peak bytes count, big-endian.
               if (byte_idx < PEAK_USED_BYTES) begin
                  accum = accum | (ACCUM_W'(b) << (16 - 8 * int'(byte_idx)));
               end
               byte_idx = byte_idx + 1'b1;
               if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
               if (bytes_left == 0) done = 1'b1;
            end
         endcase
         if (done) begin
            phase = PH_CHAN;
            if (chan == CHAN_MASTER && (target == TGT_TRACK || target == TGT_ALBUM)) begin
               g.gain_target = target;
               g.gain_q9     = gain;
               g.peak_q23    = '0;
               if (bit_count != 0) begin
                  sh         = (int'(bit_count) - 1) & 7;
                  g.peak_q23 = PEAK_W'(({8'h00, accum} << 7) >> sh);
               end
               pending_gains.push_back(g);
            end
         end
         if (last) begin
            phase  = PH_CHAN;
            target = TGT_NONE;
         end
      endfunction

      function void note_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected 0x%h, got 0x%h", $time, what, want, got);
         end
      endfunction

      function void check_gain(input logic [TARGET_W-1:0] t, input logic [GAIN_W-1:0] g9,
                               input logic [31:0] peak_word);
         result_type want;
         gains_checked++;
         if (pending_gains.size() == 0) begin
            note_mismatch("result with none pending, gain_q9", 32'h0, 32'(g9));
            return;
         end
         want = pending_gains.pop_front();
         if (t !== want.gain_target) begin
            note_mismatch("gain_target", 32'(want.gain_target), 32'(t));
         end
         if (g9 !== want.gain_q9) begin
            note_mismatch("gain_q9", 32'(want.gain_q9), 32'(g9));
         end
         if (peak_word !== {1'b0, want.peak_q23}) begin
            note_mismatch("peak_q23 with pad bit", {1'b0, want.peak_q23}, peak_word);
         end
      endfunction

      function void flag_leftovers();
         if (pending_gains.size() != 0) begin
            errors += pending_gains.size();
            $display("%0d expected gain results never arrived", pending_gains.size());
         end
      endfunction
   endclass

   // Drive every block input to a known value from time zero.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int          send_idle_pct  = 26;
   int          recv_idle_pct  = 52;
   int          bytes_sent     = 0;
   int          frames_sent    = 0;
   bit          long_hold_req  = 1'b0;
   bit          long_hold_done = 1'b0;
   gain_tracker tracker;

   rva2_gain_record_decoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // Offer one payload byte, idling at random first, and hold it until the
   // block takes the transfer. Leave tvalid high so back-to-back bytes flow.
   task automatic send_byte(input logic [7:0] b, input logic [TARGET_W-1:0] t,
                            input logic first, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {first, t};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send a run of payload bytes. Only the opening byte's target matters to
   // the block, so randomize the target bits on the rest to toggle them too.
   task automatic send_frame(input logic [7:0] beats[$], input logic [TARGET_W-1:0] t,
                             input bit with_first, input bit with_last);
      foreach (beats[i]) begin
         send_byte(beats[i], (i == 0) ? t : TARGET_W'($urandom),
                   with_first && (i == 0), with_last && (i == beats.size() - 1));
      end
      frames_sent++;
   endtask

   // Build a frame of well-formed records with random content, then mostly
   // send it whole; otherwise cut it short, leave it open, or send it as
   // stray bytes with no frame markers.
   task automatic send_random_frame();
      logic [7:0]          beats[$];
      logic [TARGET_W-1:0] t;
      int                  pick;
      int                  n_bits;
      int                  keep;
      pick = $urandom_range(99);
      t = (pick < 45) ? TGT_TRACK : (pick < 90) ? TGT_ALBUM :
          (pick < 95) ? TGT_NONE : TGT_RESERVED;
      repeat ($urandom_range(1, 4)) begin
         beats.push_back(($urandom_range(99) < 75) ? CHAN_MASTER : 8'($urandom));
         beats.push_back(8'($urandom));
         beats.push_back(8'($urandom));
         // Keep most peaks short; a few run long to exercise ignored bytes.
         pick   = $urandom_range(99);
         n_bits = (pick < 20) ? 0 : (pick < 85) ? $urandom_range(1, 24) :
                  (pick < 95) ? $urandom_range(25, 64) : $urandom_range(65, 255);
         beats.push_back(8'(n_bits));
         repeat ((n_bits + 7) / 8) beats.push_back(8'($urandom));
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
         send_frame(beats, t, 1'b1, 1'b1);
      end else begin
         keep  = $urandom_range(1, beats.size() - 1);
         beats = beats[0:keep-1];
         if (pick < 88) begin
            send_frame(beats, t, 1'b1, 1'b1);
         end else if (pick < 95) begin
            send_frame(beats, t, 1'b1, 1'b0);
         end else begin
            send_frame(beats, t, 1'b0, 1'b0);
         end
      end
   endtask

   // Stop offering bytes and wait until every owed result has come out,
   // then give the block time to show any stray result.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_gains.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: stall at random, and once, on request, hold off for a long
   // stretch so the output slots fill and the block backs up its input.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Sample both channels at the clock edge; note the accepted byte first so
   // a result is never checked before the byte that owes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.take_byte(req_tdata, req_tuser[1:0], req_tuser[2], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_gain(rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16]);
         end
      end
   end

   initial begin
      logic [7:0] beats[$];
      int         stop_at;
      tracker = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Track frame: zero peak bits with the largest gain, then the most
      // negative gain with a 25-bit peak, all ones, plus an ignored fourth byte.
      beats = {8'h01, 8'h7F, 8'hFF, 8'h00,
               8'h01, 8'h80, 8'h00, 8'h19, 8'hFF, 8'hFF, 8'hFF, 8'hAB};
      send_frame(beats, TGT_TRACK, 1'b1, 1'b1);
      // Stray bytes outside any frame leave a record half parsed.
      beats = {8'hAA, 8'hBB};
      send_frame(beats, TGT_NONE, 1'b0, 1'b0);
      // A new frame abandons it; this one has the reserved target and ends
      // in the middle of its record.
      beats = {8'h01, 8'h55, 8'h66};
      send_frame(beats, TGT_RESERVED, 1'b1, 1'b1);
      // Album frame: a non-master record, then a master one with a 1-bit peak.
      beats = {8'h05, 8'h12, 8'h34, 8'h00, 8'h01, 8'h00, 8'h01, 8'h01, 8'h80};
      send_frame(beats, TGT_ALBUM, 1'b1, 1'b1);
      wait_for_results();

      // Random frames under three idle mixes; drain between mixes. The last
      // mix has no random idling but carries the long result hold-off.
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 26 : (p == 1) ? 52 : 0;
         recv_idle_pct = (p == 0) ? 52 : (p == 1) ? 26 : 0;
         if (p == 2) long_hold_req = 1'b1;
         stop_at = bytes_sent + ITEMS_PER_PHASE;
         while (bytes_sent < stop_at) send_random_frame();
         wait_for_results();
      end

      tracker.flag_leftovers();
      $display("Sent %0d payload bytes in %0d frames; %0d gain results checked, %0d errors.",
               bytes_sent, frames_sent, tracker.gains_checked, tracker.errors);
      $display("Idle mixes: sender/receiver 26/52, 52/26, none; one %0d-cycle result hold-off.",
               LONG_HOLD_CYCLES);
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out waiting on the block");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
